[hw/rtl/sltk_pkg.sv]
// Shared types, token kind codes and character helpers for the script lexer.
// Depends on nothing; every other file in the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package sltk_pkg;

    typedef logic [5:0] t_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_source;
    } t_in;

    typedef struct packed {
        t_kind       token_kind;
        logic [15:0] start_offset;
        logic [15:0] token_length;
        logic [15:0] line_number;
        logic        last_of_run;
    } t_out;

    // Up to three tokens are written into the result queue per input beat.
    typedef struct packed {
        logic [1:0]     n;
        t_out [2:0]     ent;
    } t_push;

    localparam t_kind K_LPAREN   = 6'd0;
    localparam t_kind K_RPAREN   = 6'd1;
    localparam t_kind K_LBRACK   = 6'd2;
    localparam t_kind K_RBRACK   = 6'd3;
    localparam t_kind K_LBRACE   = 6'd4;
    localparam t_kind K_RBRACE   = 6'd5;
    localparam t_kind K_PLUS     = 6'd6;
    localparam t_kind K_MINUS    = 6'd7;
    localparam t_kind K_SLASH    = 6'd8;
    localparam t_kind K_STAR     = 6'd9;
    localparam t_kind K_POW      = 6'd10;
    localparam t_kind K_DOT      = 6'd11;
    localparam t_kind K_DOT_DOT  = 6'd12;
    localparam t_kind K_COMMA    = 6'd13;
    localparam t_kind K_BANG     = 6'd14;
    localparam t_kind K_NE       = 6'd15;
    localparam t_kind K_ASSIGN   = 6'd16;
    localparam t_kind K_EQ       = 6'd17;
    localparam t_kind K_SEMI     = 6'd18;
    localparam t_kind K_LT       = 6'd19;
    localparam t_kind K_LE       = 6'd20;
    localparam t_kind K_GT       = 6'd21;
    localparam t_kind K_GE       = 6'd22;
    localparam t_kind K_KEYWORD0 = 6'd23;
    localparam t_kind K_IDENT    = 6'd42;
    localparam t_kind K_NUMBER   = 6'd43;
    localparam t_kind K_STRING   = 6'd44;
    localparam t_kind K_ERR_CHAR = 6'd45;
    localparam t_kind K_ERR_STR  = 6'd46;
    localparam t_kind K_EOF      = 6'd47;

    localparam int NUM_KEYWORDS = 19;
    localparam int KW_BYTES     = 8;

    // Keyword text, right aligned: the first character is the most significant byte.
    localparam logic [63:0] KW_TEXT [NUM_KEYWORDS] = '{
        64'("var"), 64'("const"), 64'("for"), 64'("while"), 64'("if"),
        64'("else"), 64'("do"), 64'("then"), 64'("end"), 64'("break"),
        64'("in"), 64'("and"), 64'("or"), 64'("is"), 64'("null"),
        64'("true"), 64'("false"), 64'("return"), 64'("function")
    };
    localparam int KW_LEN [NUM_KEYWORDS] = '{
        3, 5, 3, 5, 2, 4, 2, 4, 3, 5, 2, 3, 2, 2, 4, 4, 5, 6, 8
    };

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_name(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    endfunction

    // pre holds the first name bytes, byte i at bits [8i+7:8i]; n is the name count.
    function automatic t_kind kw_kind(input logic [63:0] pre, input int unsigned n);
        t_kind kind;
        logic  hit;
        kind = K_IDENT;
        for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
            hit = (n == KW_LEN[k]);
            for (int i = 0; i < KW_BYTES; i++) begin
                if (i < KW_LEN[k]) begin
                    if (pre[8*i +: 8] != KW_TEXT[k][8*(KW_LEN[k]-1-i) +: 8]) begin
                        hit = 1'b0;
                    end
                end
            end
            if (hit) begin
                kind = K_KEYWORD0 + 6'(k);
            end
        end
        return kind;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/sltk_result_queue.sv]
// Four-entry token queue: takes up to three tokens per beat, hands out one.
// Depends on sltk_pkg for the token and push types.
`timescale 1ns / 1ps
`default_nettype none

module sltk_result_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  sltk_pkg::t_push      i_push,
    output sltk_pkg::t_out       o_data,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic [2:0]           o_count
);
    import sltk_pkg::*;

    t_out       r_mem [4];
    logic [1:0] r_wr;
    logic [1:0] r_rd;
    logic [2:0] r_cnt;
    logic       pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_cnt != 3'd0);
    assign o_data  = r_mem[r_rd];
    assign o_count = r_cnt;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (2'(k) < i_push.n) begin
                r_mem[r_wr + 2'(k)] <= i_push.ent[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + i_push.n;
            r_rd  <= r_rd + 2'(pop);
            r_cnt <= r_cnt + 3'(i_push.n) - 3'(pop);
        end
    end

`ifndef ASSERT_OFF
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4) else $error("queue count above depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.n != 2'd0) |-> (4'(r_cnt) + 4'(i_push.n) - 4'(pop) <= 4'd4))
        else $error("queue written beyond free space");
    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.n == 2'd0 && !pop) |=> $stable(r_cnt))
        else $error("queue count moved without push or pop");
`endif

endmodule

`default_nettype wire

[hw/rtl/script_lexer_tokenizer_top.sv]
// Tokens enter the result queue as the byte that closes them is taken and leave in order.
// Throughput: one byte per cycle while each byte yields at most one token and the
// output is ready; a byte yielding two or three tokens stalls the input as the queue drains.
// Input ready is high while the four-entry result queue holds at most one token.
// Reset (synchronous, active low) returns to the idle scan state, offset 0, line 1.
// Depends on sltk_pkg and sltk_result_queue.
`timescale 1ns / 1ps
`default_nettype none

module script_lexer_tokenizer_top #(
    parameter int OFFSET_BITS     = 16,
    parameter int KEYWORD_MAX_LEN = 8
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  sltk_pkg::t_in   i_data,
    output logic            o_valid,
    input  wire logic       i_ready,
    output sltk_pkg::t_out  o_data
);
    import sltk_pkg::*;

    localparam int OW = OFFSET_BITS;
    localparam int CW = $clog2(KEYWORD_MAX_LEN + 2);
    localparam int IW = $clog2(KEYWORD_MAX_LEN);
    localparam logic [OW-1:0] POS_MAX = '1;

    typedef enum logic [3:0] {
        M_IDLE, M_NAME, M_INT, M_INT_DOT, M_FRAC, M_STRING, M_COMMENT,
        M_MINUS, M_STAR, M_DOT, M_BANG, M_EQ, M_LT, M_GT, M_EOF_OWED
    } t_mode;

    typedef struct packed {
        logic       ok;
        logic [7:0] second;
        t_kind      one;
        t_kind      two;
    } t_pair;

    t_mode         r_mode, n_mode;
    logic [OW-1:0] r_begin, n_begin;
    logic [OW-1:0] r_pos, n_pos;
    logic [15:0]   r_line, n_line;
    logic [7:0]    r_prefix [KEYWORD_MAX_LEN];
    logic [7:0]    n_prefix [KEYWORD_MAX_LEN];
    logic [CW-1:0] r_ncount, n_ncount;
    logic          r_fin, n_fin;

    t_out          ents [4];
    logic [2:0]    cnt;
    logic          accept;
    t_push         push;
    logic [2:0]    q_count;

    function automatic logic [OW-1:0] sat_inc(input logic [OW-1:0] p);
        return (p < POS_MAX) ? p + 1'b1 : p;
    endfunction

    function automatic logic [15:0] clamp16(input logic [OW-1:0] v);
        return (v > OW'(16'hFFFF)) ? 16'hFFFF : 16'(v);
    endfunction

    function automatic t_out mk(input t_kind k, input logic [OW-1:0] b,
                                input logic [OW-1:0] e, input logic [15:0] ln);
        t_out t;
        t.token_kind   = k;
        t.start_offset = clamp16(b);
        t.token_length = clamp16((e >= b) ? e - b : '0);
        t.line_number  = ln;
        t.last_of_run  = 1'b0;
        return t;
    endfunction

    function automatic t_pair pair_info(input t_mode m);
        t_pair r;
        r = '0;
        case (m)
            M_STAR:  r = '{1'b1, "*", K_STAR, K_POW};
            M_DOT:   r = '{1'b1, ".", K_DOT, K_DOT_DOT};
            M_BANG:  r = '{1'b1, "=", K_BANG, K_NE};
            M_EQ:    r = '{1'b1, "=", K_ASSIGN, K_EQ};
            M_LT:    r = '{1'b1, "=", K_LT, K_LE};
            M_GT:    r = '{1'b1, "=", K_GT, K_GE};
            default: r = '0;
        endcase
        return r;
    endfunction

    // One pass per beat: send an owed end-of-file, or close tokens, start one and flush at end.
    always_comb begin
        logic [7:0]    c;
        logic          endf;
        logic          go_idle;
        logic [OW-1:0] p;
        logic [OW-1:0] dot;
        logic [63:0]   pre;
        t_pair         pr;

        c        = i_data.data_byte;
        endf     = i_data.end_of_source || (c == 8'd0);
        p        = r_pos;
        n_mode   = r_mode;
        n_begin  = r_begin;
        n_pos    = r_pos;
        n_line   = r_line;
        n_prefix = r_prefix;
        n_ncount = r_ncount;
        n_fin    = r_fin;
        cnt      = '0;
        go_idle  = 1'b0;
        dot      = (p > '0) ? p - 1'b1 : '0;
        pre      = '0;
        for (int i = 0; i < KW_BYTES; i++) begin
            pre[8*i +: 8] = r_prefix[i];
        end
        pr = pair_info(r_mode);
        for (int k = 0; k < 4; k++) begin
            ents[k] = '0;
        end

        if (r_fin) begin
            cnt = '0;
        end else if (r_mode == M_EOF_OWED) begin
            ents[0] = mk(K_EOF, r_pos, r_pos, r_line);
            cnt     = 3'd1;
            n_fin   = 1'b1;
            n_mode  = M_IDLE;
        end else begin
            if (c != 8'd0) begin
                case (r_mode)
                    M_NAME: begin
                        if (is_name(c) || is_digit(c)) begin
                            if (r_ncount < CW'(KEYWORD_MAX_LEN)) begin
                                n_prefix[r_ncount[IW-1:0]] = c;
                            end
                            if (r_ncount <= CW'(KEYWORD_MAX_LEN)) begin
                                n_ncount = r_ncount + 1'b1;
                            end
                        end else begin
                            ents[cnt[1:0]] = mk(kw_kind(pre, int'(r_ncount)), n_begin, p,
                                                n_line);
                            cnt = cnt + 3'd1;
                            go_idle = 1'b1;
                        end
                    end
                    M_INT: begin
                        if (c == ".") begin
                            n_mode = M_INT_DOT;
                        end else if (!is_digit(c)) begin
                            ents[cnt[1:0]] = mk(K_NUMBER, n_begin, p, n_line);
                            cnt = cnt + 3'd1;
                            go_idle = 1'b1;
                        end
                    end
                    M_INT_DOT: begin
                        if (is_digit(c)) begin
                            n_mode = M_FRAC;
                        end else begin
                            ents[cnt[1:0]] = mk(K_NUMBER, n_begin, dot, n_line);
                            cnt = cnt + 3'd1;
                            n_begin = dot;
                            if (c == ".") begin
                                ents[cnt[1:0]] = mk(K_DOT_DOT, dot, sat_inc(p), n_line);
                                cnt = cnt + 3'd1;
                                n_mode = M_IDLE;
                            end else begin
                                ents[cnt[1:0]] = mk(K_DOT, dot, p, n_line);
                                cnt = cnt + 3'd1;
                                go_idle = 1'b1;
                            end
                        end
                    end
                    M_FRAC: begin
                        if (!is_digit(c)) begin
                            ents[cnt[1:0]] = mk(K_NUMBER, n_begin, p, n_line);
                            cnt = cnt + 3'd1;
                            go_idle = 1'b1;
                        end
                    end
                    M_STRING: begin
                        if (c == "\"") begin
                            ents[cnt[1:0]] = mk(K_STRING, n_begin, sat_inc(p), n_line);
                            cnt = cnt + 3'd1;
                            n_mode = M_IDLE;
                        end else if (c == "\n" && n_line != 16'hFFFF) begin
                            n_line = n_line + 16'd1;
                        end
                    end
                    M_COMMENT: begin
                        if (c == "\n") begin
                            go_idle = 1'b1;
                        end
                    end
                    M_MINUS: begin
                        if (c == "-") begin
                            n_mode = M_COMMENT;
                        end else begin
                            ents[cnt[1:0]] = mk(K_MINUS, n_begin, p, n_line);
                            cnt = cnt + 3'd1;
                            go_idle = 1'b1;
                        end
                    end
                    default: begin
                        if (pr.ok && c == pr.second) begin
                            ents[cnt[1:0]] = mk(pr.two, n_begin, sat_inc(p), n_line);
                            cnt = cnt + 3'd1;
                            n_mode = M_IDLE;
                        end else begin
                            if (pr.ok) begin
                                ents[cnt[1:0]] = mk(pr.one, n_begin, p, n_line);
                                cnt = cnt + 3'd1;
                            end
                            go_idle = 1'b1;
                        end
                    end
                endcase

                if (go_idle) begin
                    n_mode = M_IDLE;
                    if (c == "\n") begin
                        if (n_line != 16'hFFFF) begin
                            n_line = n_line + 16'd1;
                        end
                    end else if (c != " " && c != "\r" && c != "\t") begin
                        n_begin = p;
                        if (is_digit(c)) begin
                            n_mode = M_INT;
                        end else if (is_name(c)) begin
                            n_prefix[0] = c;
                            n_ncount    = CW'(1);
                            n_mode      = M_NAME;
                        end else begin
                            case (c)
                                "\"":    n_mode = M_STRING;
                                "-":     n_mode = M_MINUS;
                                "*":     n_mode = M_STAR;
                                ".":     n_mode = M_DOT;
                                "!":     n_mode = M_BANG;
                                "=":     n_mode = M_EQ;
                                "<":     n_mode = M_LT;
                                ">":     n_mode = M_GT;
                                default: n_mode = M_IDLE;
                            endcase
                            if (n_mode == M_IDLE) begin
                                case (c)
                                    "(":     ents[cnt[1:0]] = mk(K_LPAREN, p, sat_inc(p), n_line);
                                    ")":     ents[cnt[1:0]] = mk(K_RPAREN, p, sat_inc(p), n_line);
                                    "[":     ents[cnt[1:0]] = mk(K_LBRACK, p, sat_inc(p), n_line);
                                    "]":     ents[cnt[1:0]] = mk(K_RBRACK, p, sat_inc(p), n_line);
                                    "{":     ents[cnt[1:0]] = mk(K_LBRACE, p, sat_inc(p), n_line);
                                    "}":     ents[cnt[1:0]] = mk(K_RBRACE, p, sat_inc(p), n_line);
                                    "+":     ents[cnt[1:0]] = mk(K_PLUS, p, sat_inc(p), n_line);
                                    "/":     ents[cnt[1:0]] = mk(K_SLASH, p, sat_inc(p), n_line);
                                    ",":     ents[cnt[1:0]] = mk(K_COMMA, p, sat_inc(p), n_line);
                                    ";":     ents[cnt[1:0]] = mk(K_SEMI, p, sat_inc(p), n_line);
                                    default: ents[cnt[1:0]] = mk(K_ERR_CHAR, p, sat_inc(p),
                                                                 n_line);
                                endcase
                                cnt = cnt + 3'd1;
                            end
                        end
                    end
                end
                n_pos = sat_inc(p);
            end

            if (endf) begin
                dot = (n_pos > '0) ? n_pos - 1'b1 : '0;
                pr  = pair_info(n_mode);
                case (n_mode)
                    M_NAME: begin
                        for (int i = 0; i < KW_BYTES; i++) begin
                            pre[8*i +: 8] = n_prefix[i];
                        end
                        ents[cnt[1:0]] = mk(kw_kind(pre, int'(n_ncount)), n_begin, n_pos,
                                            n_line);
                        cnt = cnt + 3'd1;
                    end
                    M_INT, M_FRAC: begin
                        ents[cnt[1:0]] = mk(K_NUMBER, n_begin, n_pos, n_line);
                        cnt = cnt + 3'd1;
                    end
                    M_INT_DOT: begin
                        ents[cnt[1:0]] = mk(K_NUMBER, n_begin, dot, n_line);
                        cnt = cnt + 3'd1;
                        ents[cnt[1:0]] = mk(K_DOT, dot, n_pos, n_line);
                        cnt = cnt + 3'd1;
                    end
                    M_STRING: begin
                        ents[cnt[1:0]] = mk(K_ERR_STR, n_begin, n_pos, n_line);
                        cnt = cnt + 3'd1;
                    end
                    M_MINUS: begin
                        ents[cnt[1:0]] = mk(K_MINUS, n_begin, n_pos, n_line);
                        cnt = cnt + 3'd1;
                    end
                    default: begin
                        if (pr.ok) begin
                            ents[cnt[1:0]] = mk(pr.one, n_begin, n_pos, n_line);
                            cnt = cnt + 3'd1;
                        end
                    end
                endcase
                n_mode = M_IDLE;
                n_fin  = 1'b1;
                // A fourth token does not fit in one beat; the end-of-file token goes next.
                if (cnt == 3'd4) begin
                    cnt    = 3'd3;
                    n_fin  = 1'b0;
                    n_mode = M_EOF_OWED;
                end else begin
                    ents[cnt[1:0]] = mk(K_EOF, n_pos, n_pos, n_line);
                    cnt = cnt + 3'd1;
                    if (cnt == 3'd4) begin
                        cnt    = 3'd3;
                        n_fin  = 1'b0;
                        n_mode = M_EOF_OWED;
                    end
                end
            end
        end

        if (cnt != 3'd0) begin
            ents[cnt[1:0] - 2'd1].last_of_run = 1'b1;
        end
    end

    assign o_ready = (q_count <= 3'd1);
    assign accept  = i_valid && o_ready;

    always_comb begin
        push.n = accept ? cnt[1:0] : 2'd0;
        for (int k = 0; k < 3; k++) begin
            push.ent[k] = ents[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_begin  <= '0;
            r_pos    <= '0;
            r_line   <= 16'd1;
            r_ncount <= '0;
            r_fin    <= 1'b0;
        end else if (accept) begin
            r_mode   <= n_mode;
            r_begin  <= n_begin;
            r_pos    <= n_pos;
            r_line   <= n_line;
            r_ncount <= n_ncount;
            r_fin    <= n_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prefix <= n_prefix;
        end
    end

    sltk_result_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_data  (o_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_count (q_count)
    );

`ifndef ASSERT_OFF
    a_fin_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |-> (r_mode == M_IDLE)) else $error("finished with a token still open");
    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line != 16'd0) else $error("line counter reached zero");
    a_fin_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_fin) |-> (push.n == 2'd0)) else $error("tokens after end of file");
    a_owed_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_mode == M_EOF_OWED) |=> r_fin) else $error("owed end of file lost");
`endif

endmodule

`default_nettype wire

[dv/sltk_token_checker.sv]
// Token checker for the script lexer: watches both channels, predicts the token stream
// from the accepted source bytes, and compares every result beat field by field.
// Depends on sltk_pkg for the beat types and token kind codes.
`timescale 1ns / 1ps

module sltk_token_checker
    import sltk_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_in_valid,
    input  wire logic   i_in_ready,
    input  t_in         i_in_data,
    input  wire logic   i_out_valid,
    input  wire logic   i_out_ready,
    input  t_out        i_out_data,
    output int          o_fail_count,
    output int          o_pending
);

    localparam longint POS_MAX  = (64'd1 << 16) - 1;
    localparam int     NAME_MAX = 8;

    typedef enum int {
        SC_IDLE, SC_NAME, SC_INT, SC_INT_DOT, SC_FRAC, SC_STRING, SC_COMMENT,
        SC_MINUS, SC_STAR, SC_DOT, SC_BANG, SC_EQ, SC_LT, SC_GT, SC_EOF_OWED
    } t_scan;

    string keywords [19] = '{
        "var", "const", "for", "while", "if", "else", "do", "then", "end", "break",
        "in", "and", "or", "is", "null", "true", "false", "return", "function"
    };

    t_scan        scan;
    logic [7:0]   name_buf [NAME_MAX];
    int           name_len;
    longint       tok_start;
    longint       byte_pos;
    longint       line_no;
    bit           done;
    t_out         beat_tokens [$];
    t_out         expected_tokens [$];
    int           mismatches;

    assign o_fail_count = mismatches;
    assign o_pending    = expected_tokens.size();

    function automatic longint clamp16(longint v);
        return (v > 65535) ? 65535 : v;
    endfunction

    function automatic longint step_pos(longint p);
        return (p < POS_MAX) ? p + 1 : p;
    endfunction

    function automatic bit digit_char(logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic bit name_char(logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    endfunction

    task automatic add_token(t_kind kind, longint b, longint e);
        t_out tok;
        if (beat_tokens.size() >= 4) begin
            return;
        end
        tok.token_kind   = kind;
        tok.start_offset = 16'(clamp16(b));
        tok.token_length = 16'(clamp16((e >= b) ? e - b : 0));
        tok.line_number  = 16'(clamp16(line_no));
        tok.last_of_run  = 1'b0;
        beat_tokens.push_back(tok);
    endtask

    function automatic t_kind classify_name();
        bit hit;
        for (int k = 0; k < 19; k++) begin
            hit = (name_len == keywords[k].len());
            for (int i = 0; i < keywords[k].len() && hit; i++) begin
                if (name_buf[i] != keywords[k][i]) begin
                    hit = 0;
                end
            end
            if (hit) begin
                return K_KEYWORD0 + 6'(k);
            end
        end
        return K_IDENT;
    endfunction

    // Operators that may take a second character: which one, and the two kinds.
    function automatic bit pair_of(t_scan m, output logic [7:0] second,
                                   output t_kind one, output t_kind two);
        second = "=";
        case (m)
            SC_STAR: begin second = "*"; one = K_STAR;   two = K_POW;     end
            SC_DOT:  begin second = "."; one = K_DOT;    two = K_DOT_DOT; end
            SC_BANG: begin one = K_BANG;   two = K_NE; end
            SC_EQ:   begin one = K_ASSIGN; two = K_EQ; end
            SC_LT:   begin one = K_LT;     two = K_LE; end
            SC_GT:   begin one = K_GT;     two = K_GE; end
            default: begin one = K_EOF;    two = K_EOF; return 0; end
        endcase
        return 1;
    endfunction

    task automatic bump_line();
        if (line_no < 65535) begin
            line_no++;
        end
    endtask

    task automatic start_token(logic [7:0] c, longint p);
        t_kind single;
        scan = SC_IDLE;
        if (c == " " || c == 8'h0d || c == 8'h09) begin
            return;
        end
        if (c == 8'h0a) begin
            bump_line();
            return;
        end
        tok_start = p;
        if (digit_char(c)) begin
            scan = SC_INT;
            return;
        end
        if (name_char(c)) begin
            name_buf[0] = c;
            name_len    = 1;
            scan        = SC_NAME;
            return;
        end
        case (c)
            "(": single = K_LPAREN;
            ")": single = K_RPAREN;
            "[": single = K_LBRACK;
            "]": single = K_RBRACK;
            "{": single = K_LBRACE;
            "}": single = K_RBRACE;
            "+": single = K_PLUS;
            "/": single = K_SLASH;
            ",": single = K_COMMA;
            ";": single = K_SEMI;
            "\"": begin scan = SC_STRING; return; end
            "-": begin scan = SC_MINUS; return; end
            "*": begin scan = SC_STAR; return; end
            ".": begin scan = SC_DOT; return; end
            "!": begin scan = SC_BANG; return; end
            "=": begin scan = SC_EQ; return; end
            "<": begin scan = SC_LT; return; end
            ">": begin scan = SC_GT; return; end
            default: single = K_ERR_CHAR;
        endcase
        add_token(single, p, step_pos(p));
    endtask

    task automatic take_char(logic [7:0] c, longint p);
        logic [7:0] second;
        t_kind      one, two;
        longint     dot;
        case (scan)
            SC_NAME: begin
                if (name_char(c) || digit_char(c)) begin
                    if (name_len < NAME_MAX) begin
                        name_buf[name_len] = c;
                    end
                    if (name_len <= NAME_MAX) begin
                        name_len++;
                    end
                    return;
                end
                add_token(classify_name(), tok_start, p);
            end
            SC_INT: begin
                if (digit_char(c)) begin
                    return;
                end
                if (c == ".") begin
                    scan = SC_INT_DOT;
                    return;
                end
                add_token(K_NUMBER, tok_start, p);
            end
            SC_INT_DOT: begin
                if (digit_char(c)) begin
                    scan = SC_FRAC;
                    return;
                end
                dot = (p > 0) ? p - 1 : 0;
                add_token(K_NUMBER, tok_start, dot);
                tok_start = dot;
                if (c == ".") begin
                    add_token(K_DOT_DOT, dot, step_pos(p));
                    scan = SC_IDLE;
                    return;
                end
                add_token(K_DOT, dot, p);
            end
            SC_FRAC: begin
                if (digit_char(c)) begin
                    return;
                end
                add_token(K_NUMBER, tok_start, p);
            end
            SC_STRING: begin
                if (c == "\"") begin
                    add_token(K_STRING, tok_start, step_pos(p));
                    scan = SC_IDLE;
                    return;
                end
                if (c == 8'h0a) begin
                    bump_line();
                end
                return;
            end
            SC_COMMENT: begin
                if (c != 8'h0a) begin
                    return;
                end
            end
            SC_MINUS: begin
                if (c == "-") begin
                    scan = SC_COMMENT;
                    return;
                end
                add_token(K_MINUS, tok_start, p);
            end
            default: begin
                if (pair_of(scan, second, one, two)) begin
                    if (c == second) begin
                        add_token(two, tok_start, step_pos(p));
                        scan = SC_IDLE;
                        return;
                    end
                    add_token(one, tok_start, p);
                end
            end
        endcase
        start_token(c, p);
    endtask

    task automatic close_source(longint p);
        logic [7:0] second;
        t_kind      one, two;
        longint     dot;
        case (scan)
            SC_NAME: add_token(classify_name(), tok_start, p);
            SC_INT, SC_FRAC: add_token(K_NUMBER, tok_start, p);
            SC_INT_DOT: begin
                dot = (p > 0) ? p - 1 : 0;
                add_token(K_NUMBER, tok_start, dot);
                add_token(K_DOT, dot, p);
            end
            SC_STRING: add_token(K_ERR_STR, tok_start, p);
            SC_MINUS: add_token(K_MINUS, tok_start, p);
            default: begin
                if (pair_of(scan, second, one, two)) begin
                    add_token(one, tok_start, p);
                end
            end
        endcase
        scan = SC_IDLE;
        add_token(K_EOF, p, p);
    endtask

    task automatic predict_beat(t_in d);
        logic [7:0] c;
        bit         last_byte;
        c         = d.data_byte;
        last_byte = d.end_of_source || (c == 8'h00);
        beat_tokens.delete();
        if (done) begin
            return;
        end
        if (scan == SC_EOF_OWED) begin
            add_token(K_EOF, byte_pos, byte_pos);
            done = 1;
            scan = SC_IDLE;
        end else begin
            if (c != 8'h00) begin
                take_char(c, byte_pos);
                byte_pos = step_pos(byte_pos);
            end
            if (last_byte) begin
                close_source(byte_pos);
                done = 1;
                // A fourth token does not fit in one beat; the end-of-file token waits.
                if (beat_tokens.size() > 3) begin
                    beat_tokens = beat_tokens[0:2];
                    done = 0;
                    scan = SC_EOF_OWED;
                end
            end
        end
        if (beat_tokens.size() > 0) begin
            beat_tokens[$].last_of_run = 1'b1;
        end
        foreach (beat_tokens[i]) begin
            expected_tokens.push_back(beat_tokens[i]);
        end
    endtask

    task automatic check_token(t_out got);
        t_out want;
        if (expected_tokens.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("unexpected token beat: %p", got);
            end
            return;
        end
        want = expected_tokens.pop_front();
        if (got.token_kind !== want.token_kind || got.start_offset !== want.start_offset
                || got.token_length !== want.token_length
                || got.line_number !== want.line_number
                || got.last_of_run !== want.last_of_run) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("token mismatch: expected %p, got %p", want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            scan      = SC_IDLE;
            name_len  = 0;
            tok_start = 0;
            byte_pos  = 0;
            line_no   = 1;
            done      = 0;
            foreach (name_buf[i]) begin
                name_buf[i] = 8'h00;
            end
            expected_tokens.delete();
            mismatches = 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                predict_beat(i_in_data);
            end
            if (i_out_valid && i_out_ready) begin
                check_token(i_out_data);
            end
        end
    end

endmodule

[dv/tb_script_lexer_tokenizer_top.sv]
// Testbench top for the script lexer: drives one long source text with random gaps
// and output stalls, and reports the verdict from sltk_token_checker.
// Depends on sltk_pkg, script_lexer_tokenizer_top and sltk_token_checker.
`timescale 1ns / 1ps

module tb_script_lexer_tokenizer_top;

    import sltk_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic src_valid;
    logic src_ready;
    t_in  src_data;
    logic tok_valid;
    logic tok_ready;
    t_out tok_data;
    int   fail_count;
    int   pending;
    int   gap_pct;
    int   stall_pct;
    int   rx_cycles;
    int   hold_left;

    script_lexer_tokenizer_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (src_valid),
        .o_ready (src_ready),
        .i_data  (src_data),
        .o_valid (tok_valid),
        .i_ready (tok_ready),
        .o_data  (tok_data)
    );

    sltk_token_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (src_valid),
        .i_in_ready   (src_ready),
        .i_in_data    (src_data),
        .i_out_valid  (tok_valid),
        .i_out_ready  (tok_ready),
        .i_out_data   (tok_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // The receiver counts its own cycles and once holds off for a long stretch,
    // so the result queue fills and the input stalls.
    initial begin
        tok_ready = 1'b0;
        rx_cycles = 0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            rx_cycles++;
            if (rx_cycles == 60) begin
                hold_left = 50;
            end
            if (hold_left > 0) begin
                hold_left--;
                tok_ready <= 1'b0;
            end else begin
                tok_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_byte(logic [7:0] c, logic last);
        t_in d;
        bit  took;
        d.data_byte     = c;
        d.end_of_source = last;
        while ($urandom_range(0, 99) < gap_pct) begin
            src_valid <= 1'b0;
            @(negedge i_clk);
        end
        src_valid <= 1'b1;
        src_data  <= d;
        do begin
            took = src_ready;
            @(posedge i_clk);
            @(negedge i_clk);
        end while (!took);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], 1'b0);
        end
    endtask

    function automatic logic [7:0] pick_from(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    function automatic string random_name(int n);
        string s;
        string lead;
        string rest;
        lead = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
        rest = {lead, "0123456789"};
        s = "";
        for (int i = 0; i < n; i++) begin
            s = {s, string'((i == 0) ? pick_from(lead) : pick_from(rest))};
        end
        return s;
    endfunction

    function automatic string random_digits();
        string s;
        s = "";
        repeat ($urandom_range(1, 4)) begin
            s = {s, string'(pick_from("0123456789"))};
        end
        return s;
    endfunction

    // One lexeme of the script language, mostly well formed, sometimes junk.
    function automatic string random_lexeme();
        string kw [19] = '{
            "var", "const", "for", "while", "if", "else", "do", "then", "end", "break",
            "in", "and", "or", "is", "null", "true", "false", "return", "function"
        };
        string ops [23] = '{
            "(", ")", "[", "]", "{", "}", "+", "-", "/", "*", "**", ".", "..", ",",
            "!", "!=", "=", "==", ";", "<", "<=", ">", ">="
        };
        string s;
        case ($urandom_range(0, 11))
            0, 1: s = kw[$urandom_range(0, 18)];
            2:    s = random_name($urandom_range(1, ($urandom_range(0, 3) == 0) ? 12 : 5));
            3:    s = random_digits();
            4:    s = {random_digits(), ".", random_digits()};
            5:    s = {random_digits(), ".", string'(pick_from(".x);*"))};
            6:    s = {"\"", random_name($urandom_range(0, 4)),
                       ($urandom_range(0, 2) == 0) ? "\n" : " ", "\""};
            7, 8: s = ops[$urandom_range(0, 22)];
            9:    s = {"--", random_name($urandom_range(0, 4)), "\n"};
            10:   s = string'(pick_from("@#$%^&~`|:?'\\"));
            default: s = string'(8'($urandom_range(1, 255)));
        endcase
        return s;
    endfunction

    initial begin
        int sent;
        logic [7:0] c;
        i_rst_n   = 1'b0;
        src_valid = 1'b0;
        src_data  = '0;
        gap_pct   = 0;
        stall_pct = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Keyword, number with fraction, number then range, number then dot,
        // comment, a high byte and an unknown character.
        send_text("return 4.5 7..8 3.y--c\n\377@ if");

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 59; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 59; end
                default: begin gap_pct = 9; stall_pct = 9; end
            endcase
            sent = 0;
            while (sent < 100) begin
                string lx;
                lx = random_lexeme();
                send_text(lx);
                sent += lx.len();
                send_byte(pick_from(" \t\r\n"), 1'b0);
                sent++;
            end
        end

        // A string spanning several lines, with mostly newlines and some odd bytes inside.
        gap_pct   = 0;
        stall_pct = 0;
        send_byte("\"", 1'b0);
        repeat (16) begin
            if ($urandom_range(0, 99) < 60) begin
                c = 8'h0a;
            end else begin
                do c = 8'($urandom_range(1, 255)); while (c == "\"");
            end
            send_byte(c, 1'b0);
        end
        send_byte("\"", 1'b0);
        send_text(" x2 >= 9 ");

        // The last byte closes a number, a dot and a star: the end-of-file token
        // comes on the next beat, after which the block stays silent.
        gap_pct   = 20;
        stall_pct = 30;
        send_text("12.");
        send_byte("*", 1'b1);
        send_byte("a", 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(";", 1'b1);
        src_valid <= 1'b0;

        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (20) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[script_lexer_tokenizer_top.f]
hw/rtl/sltk_pkg.sv
hw/rtl/sltk_result_queue.sv
hw/rtl/script_lexer_tokenizer_top.sv
dv/sltk_token_checker.sv
dv/tb_script_lexer_tokenizer_top.sv
